/* design/audio_downward_expander_unit_defines.svh */
// Assertion macros for the downward expander unit.
// Used by audio_downward_expander_unit.sv; no other dependencies.
`ifndef AUDIO_DOWNWARD_EXPANDER_UNIT_DEFINES_SVH
`define AUDIO_DOWNWARD_EXPANDER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ADE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ADE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ade_pkg.sv */
// Shared types and constants for the downward expander unit.
// No dependencies; used by the channel interfaces and the top level.
package ade_pkg;

	typedef logic signed [15:0] sample_t;
	typedef logic [14:0] level_t;
	typedef logic [19:0] gain_t;
	typedef logic [8:0] step_t;
	typedef logic [2:0] cfg_idx_t;
	typedef logic [19:0] cfg_data_t;

	// register indexes of the configuration channel
	localparam cfg_idx_t REG_LOWER_LEVEL = 3'd0;
	localparam cfg_idx_t REG_UPPER_LEVEL = 3'd1;
	localparam cfg_idx_t REG_LOW_GAIN    = 3'd2;
	localparam cfg_idx_t REG_FADE_STEP   = 3'd3;
	localparam cfg_idx_t REG_WET_MIX     = 3'd4;

	localparam gain_t UNITY_GAIN = 20'h10000;
	localparam step_t FADE_RESET = 9'd1;
	localparam step_t MIX_FULL   = 9'd256;
	localparam logic [16:0] SAT_POS_MAG = 17'd32767;
	localparam logic [16:0] SAT_NEG_MAG = 17'd32768;

	// shared serial datapath: numerator / accumulator and divisor widths
	localparam int DIV_W  = 36;
	localparam int DEN_W  = 15;
	localparam int MPL_W  = 16;
	localparam int STEP_W = 6;
	localparam logic [STEP_W-1:0] DIV_STEPS = 6'd36;
	localparam logic [STEP_W-1:0] MUL_STEPS = 6'd16;
	localparam logic [STEP_W-1:0] MIX_STEPS = 6'd9;

endpackage

/* design/ade_ifs.sv */
// Valid/ready channel interfaces of the downward expander unit.
// Depends on ade_pkg for the payload types.
interface ade_smp_if;
	logic valid;
	logic ready;
	ade_pkg::sample_t sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface ade_res_if;
	logic valid;
	logic ready;
	ade_pkg::sample_t sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface ade_cfg_if;
	logic valid;
	logic ready;
	ade_pkg::cfg_idx_t index;
	ade_pkg::cfg_data_t data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/audio_downward_expander_unit.sv */
// Downward expander / noise gate on signed 16-bit samples, bit-serial datapath.
// Depends on ade_pkg, ade_ifs.sv and audio_downward_expander_unit_defines.svh.
//
// channel     dir   payload                 transaction when
// sample_ch   in    sample_in  (s16)        valid & ready
// result_ch   out   sample_out (s16)        valid & ready
// cfg_ch      in    index (3), data (20)    valid & ready, always ready
//
// Each accepted item runs a 16-step shift-add gain multiply and a 9-step
// wet/dry multiply on one adder; the next item is taken only once it is done.
// The item that closes a window first computes the mean (radix-2 restoring
// divide) and, when the mean falls between the levels, the interpolation
// multiply and divide. No clearing pass after reset.
// A stalled result sits in the output register while the next item computes.
`include "audio_downward_expander_unit_defines.svh"

module audio_downward_expander_unit #(
	parameter int WINDOW_LENGTH = 256
) (
	input logic clk,
	input logic arst_n,
	ade_smp_if.sink sample_ch,
	ade_res_if.source result_ch,
	ade_cfg_if.sink cfg_ch
);
	import ade_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_LENGTH);
	localparam int SUM_W = 16 + $clog2(WINDOW_LENGTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LENGTH - 1);
	localparam logic [DEN_W-1:0] WIN_DEN = DEN_W'(WINDOW_LENGTH);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIVM = 4'd1;
	localparam logic [3:0] ST_PICK = 4'd2;
	localparam logic [3:0] ST_MUL  = 4'd3;
	localparam logic [3:0] ST_DIVG = 4'd4;
	localparam logic [3:0] ST_SLEW = 4'd5;
	localparam logic [3:0] ST_MULS = 4'd6;
	localparam logic [3:0] ST_EFF  = 4'd7;
	localparam logic [3:0] ST_MIX  = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0] state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	gain_t cur_gain_q, tgt_gain_q;
	level_t lower_q, upper_q;
	gain_t low_gain_q;
	step_t fade_q, wet_q;
	logic out_valid_q;
	sample_t out_data_q;

	sample_t sample_q;
	logic [DIV_W-1:0] num_q, mcand_q;
	logic [MPL_W-1:0] mplier_q;
	logic [DEN_W-1:0] den_q, rem_q;

	logic accept, win_end, last_step, out_free;
	logic [15:0] mag_in, mag_q, mean;
	logic [SUM_W-1:0] sum_nx;
	logic [DEN_W:0] rem_sh;
	logic div_ge;
	logic [DEN_W-1:0] rem_nx;
	gain_t gain_up, gain_dn;
	logic [19:0] prod_hi;
	logic [16:0] eff_lim, eff_mag;
	logic signed [16:0] eff, diff;
	step_t wet_eff;
	logic [DIV_W-1:0] mix_rnd;

	assign accept = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign result_ch.valid = out_valid_q;
	assign result_ch.sample_out = out_data_q;
	assign out_free = !out_valid_q || result_ch.ready;

	assign mag_in = sample_ch.sample_in[15] ? 16'(~sample_ch.sample_in + 16'd1)
		: 16'(sample_ch.sample_in);
	assign mag_q = sample_q[15] ? 16'(~sample_q + 16'd1) : 16'(sample_q);
	assign sum_nx = sum_q + SUM_W'(mag_in);
	assign win_end = (count_q == CNT_LAST);
	assign last_step = (step_q == STEP_W'(1));

	// one restoring divide step; the quotient bit shifts into num_q
	assign rem_sh = {rem_q, num_q[DIV_W-1]};
	assign div_ge = (rem_sh >= {1'b0, den_q});
	assign rem_nx = div_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
	assign mean = num_q[15:0];

	assign gain_up = tgt_gain_q - cur_gain_q;
	assign gain_dn = cur_gain_q - tgt_gain_q;

	// magnitude product / 65536, saturated, sign restored (truncates toward zero)
	assign prod_hi = num_q[35:16];
	assign eff_lim = sample_q[15] ? SAT_NEG_MAG : SAT_POS_MAG;
	assign eff_mag = (prod_hi > 20'(eff_lim)) ? eff_lim : prod_hi[16:0];
	assign eff = sample_q[15] ? 17'(17'd0 - eff_mag) : eff_mag;
	assign diff = 17'(eff - {sample_q[15], sample_q});
	assign wet_eff = (wet_q > MIX_FULL) ? MIX_FULL : wet_q;

	// (256*dry + wet*(effect - dry)) / 256 toward zero
	assign mix_rnd = num_q + (num_q[DIV_W-1] ? DIV_W'(255) : DIV_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			cur_gain_q <= UNITY_GAIN;
			tgt_gain_q <= UNITY_GAIN;
			lower_q <= '0;
			upper_q <= '0;
			low_gain_q <= '0;
			fade_q <= FADE_RESET;
			wet_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				unique case (cfg_ch.index)
					REG_LOWER_LEVEL: lower_q <= cfg_ch.data[14:0];
					REG_UPPER_LEVEL: upper_q <= cfg_ch.data[14:0];
					REG_LOW_GAIN:    low_gain_q <= cfg_ch.data;
					REG_FADE_STEP:   fade_q <= cfg_ch.data[8:0];
					REG_WET_MIX:     wet_q <= cfg_ch.data[8:0];
					default: ;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (win_end) begin
							sum_q <= '0;
							count_q <= '0;
							step_q <= DIV_STEPS;
							state_q <= ST_DIVM;
						end else begin
							sum_q <= sum_nx;
							count_q <= count_q + CNT_W'(1);
							state_q <= ST_SLEW;
						end
					end
				end
				ST_DIVM: begin
					step_q <= step_q - STEP_W'(1);
					if (last_step) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (mean < {1'b0, lower_q}) begin
						tgt_gain_q <= low_gain_q;
						state_q <= ST_SLEW;
					end else if (mean >= {1'b0, upper_q}) begin
						tgt_gain_q <= UNITY_GAIN;
						state_q <= ST_SLEW;
					end else begin
						step_q <= MUL_STEPS;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (last_step) begin
						step_q <= DIV_STEPS;
						state_q <= ST_DIVG;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_DIVG: begin
					step_q <= step_q - STEP_W'(1);
					if (last_step) begin
						tgt_gain_q <= {num_q[18:0], div_ge};
						state_q <= ST_SLEW;
					end
				end
				ST_SLEW: begin
					if (cur_gain_q < tgt_gain_q) begin
						cur_gain_q <= (gain_up <= 20'(fade_q)) ? tgt_gain_q
							: cur_gain_q + 20'(fade_q);
					end else if (cur_gain_q > tgt_gain_q) begin
						cur_gain_q <= (gain_dn <= 20'(fade_q)) ? tgt_gain_q
							: cur_gain_q - 20'(fade_q);
					end
					step_q <= MUL_STEPS;
					state_q <= ST_MULS;
				end
				ST_MULS: begin
					step_q <= step_q - STEP_W'(1);
					if (last_step) begin
						state_q <= ST_EFF;
					end
				end
				ST_EFF: begin
					step_q <= MIX_STEPS;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					step_q <= step_q - STEP_W'(1);
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q) inside
			ST_IDLE: begin
				if (accept) begin
					sample_q <= sample_ch.sample_in;
					num_q <= DIV_W'(sum_nx);
					den_q <= WIN_DEN;
					rem_q <= '0;
				end
			end
			ST_DIVM, ST_DIVG: begin
				num_q <= {num_q[DIV_W-2:0], div_ge};
				rem_q <= rem_nx;
			end
			ST_PICK: begin
				num_q <= DIV_W'({mean[14:0] - lower_q, 16'h0000});
				mcand_q <= DIV_W'(low_gain_q);
				mplier_q <= MPL_W'(upper_q - mean[14:0]);
				den_q <= upper_q - lower_q;
				rem_q <= '0;
			end
			ST_MUL, ST_MULS, ST_MIX: begin
				num_q <= num_q + (mplier_q[0] ? mcand_q : '0);
				mcand_q <= {mcand_q[DIV_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
			end
			ST_SLEW: begin
				num_q <= '0;
				mplier_q <= mag_q;
				if (cur_gain_q < tgt_gain_q) begin
					mcand_q <= DIV_W'((gain_up <= 20'(fade_q)) ? tgt_gain_q
						: cur_gain_q + 20'(fade_q));
				end else if (cur_gain_q > tgt_gain_q) begin
					mcand_q <= DIV_W'((gain_dn <= 20'(fade_q)) ? tgt_gain_q
						: cur_gain_q - 20'(fade_q));
				end else begin
					mcand_q <= DIV_W'(cur_gain_q);
				end
			end
			ST_EFF: begin
				num_q <= {{(DIV_W-24){sample_q[15]}}, sample_q, 8'h00};
				mcand_q <= {{(DIV_W-17){diff[16]}}, diff};
				mplier_q <= MPL_W'(wet_eff);
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q <= mix_rnd[23:8];
				end
			end
			default: ;
		endcase
	end

	`ADE_ASSERT_NEXT(a_busy_after_accept, accept, state_q != ST_IDLE,
		"input accepted but sequencer stayed idle")
	`ADE_ASSERT_NOW(a_result_from_done, $rose(out_valid_q), $past(state_q == ST_DONE),
		"result raised outside the completion step")
	`ADE_ASSERT_NOW(a_divisor_nonzero, state_q == ST_DIVG, den_q != '0,
		"gain interpolation divide with zero span")

endmodule
